// File: src/rrs_pkg.sv
// Shared types and constants for the round-robin time-slice scheduler.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package rrs_pkg;

  // Process count scanned per tick and ready queue depth
  localparam int PROC_CNT   = 16;
  localparam int FIFO_DEPTH = 16;
  localparam int IDX_W      = $clog2(PROC_CNT);
  localparam int ADDR_W     = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = ADDR_W + 1;
  localparam int MASK_W     = 16;
  localparam int TQ_W       = 8;
  localparam int RUN_IDX_W  = 4;

  localparam logic [TQ_W-1:0] TQ_RESET = 8'd4;

  typedef struct packed {
    logic [MASK_W-1:0] arrived_mask;
    logic [MASK_W-1:0] done_mask;
  } in_word_t;

  typedef struct packed {
    logic                 run_valid;
    logic [RUN_IDX_W-1:0] run_index;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic rd;
    logic rotate;
    logic emit;
  } rrs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic              scan_last;
    logic              out_busy;
    logic [FILL_W-1:0] fill;
    logic [PROC_CNT-1:0] queued;
  } rrs_status_t;

endpackage

`default_nettype wire

// File: src/rrs_dp.sv
// Datapath of the scheduler: ready queue memory, head/count, queued flags,
// slice counter, quantum register and output word register. Uses rrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrs_dp (
  input  wire                     clk,
  input  wire                     rst_n,
  input  rrs_pkg::rrs_cmd_t       cmd,
  output rrs_pkg::rrs_status_t    status,
  input  rrs_pkg::in_word_t       in_data,
  input  wire                     cfg_we,
  input  wire [rrs_pkg::TQ_W-1:0] cfg_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output rrs_pkg::out_word_t      out_data
);
  import rrs_pkg::*;

  logic [IDX_W-1:0]    mem [FIFO_DEPTH];
  logic [IDX_W-1:0]    rdata_r;
  logic [MASK_W-1:0]   arr_r, arr_nxt, done_r, done_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [FILL_W-1:0]   count_r, count_nxt;
  logic [PROC_CNT-1:0] queued_r, queued_nxt;
  logic [TQ_W-1:0]     slice_r, slice_nxt;
  logic [TQ_W-1:0]     tq_r;
  logic                ovalid_r, ovalid_nxt;
  out_word_t           out_r, out_nxt;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [IDX_W-1:0]    wr_data;
  logic                scan_hit;
  logic                head_done;

  assign status.scan_last = (idx_r == IDX_W'(PROC_CNT - 1));
  assign status.out_busy  = ovalid_r && !out_ready;
  assign status.fill      = count_r;
  assign status.queued    = queued_r;
  assign out_valid        = ovalid_r;
  assign out_data         = out_r;

  // Next-state logic for queue, flags, slice and output word
  always_comb begin
    arr_nxt    = arr_r;
    done_nxt   = done_r;
    idx_nxt    = idx_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    queued_nxt = queued_r;
    slice_nxt  = slice_r;
    ovalid_nxt = ovalid_r;
    out_nxt    = out_r;
    wr_en      = 1'b0;
    wr_addr    = head_r + count_r[ADDR_W-1:0];
    wr_data    = idx_r;
    scan_hit   = arr_r[idx_r] && !done_r[idx_r] && !queued_r[idx_r];
    head_done  = done_r[rdata_r];

    // Capture the tick's masks and restart the scan
    if (cmd.load) begin
      arr_nxt  = in_data.arrived_mask;
      done_nxt = in_data.done_mask;
      idx_nxt  = '0;
    end

    // Scan one process index per cycle; append it if newly arrived and room is left
    if (cmd.scan) begin
      idx_nxt = idx_r + 1'b1;
      if (scan_hit && (count_r < FILL_W'(FIFO_DEPTH))) begin
        wr_en               = 1'b1;
        count_nxt           = count_r + 1'b1;
        queued_nxt[idx_r]   = 1'b1;
      end
    end

    // Drop or rotate the head when its slice is over or it is done
    if (cmd.rotate && (count_r != '0) && ((slice_r == '0) || head_done)) begin
      head_nxt  = head_r + 1'b1;
      slice_nxt = tq_r;
      if (head_done) begin
        count_nxt           = count_r - 1'b1;
        queued_nxt[rdata_r] = 1'b0;
      end else begin
        wr_en   = 1'b1;
        wr_data = rdata_r;
      end
    end

    // Emit the result word and count the slice down
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      if (count_r != '0) begin
        out_nxt.run_valid = 1'b1;
        out_nxt.run_index = RUN_IDX_W'(rdata_r);
        if (slice_r != '0) begin
          slice_nxt = slice_r - 1'b1;
        end
      end else begin
        out_nxt   = '0;
        slice_nxt = '0;
      end
    end else if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      head_r   <= '0;
      count_r  <= '0;
      queued_r <= '0;
      slice_r  <= TQ_RESET;
      tq_r     <= TQ_RESET;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      queued_r <= queued_nxt;
      slice_r  <= slice_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        tq_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    arr_r  <= arr_nxt;
    done_r <= done_nxt;
    out_r  <= out_nxt;
  end

  // Ready queue memory: one write port, registered head read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata_r <= mem[head_r];
    end
  end

endmodule

`default_nettype wire

// File: src/rrs_ctrl.sv
// Controller state machine of the scheduler: sequences load, scan,
// head read, rotation and emit. Uses rrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrs_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  rrs_pkg::rrs_status_t status,
  output rrs_pkg::rrs_cmd_t    cmd
);
  import rrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_ROTATE,
    S_REREAD,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Decode commands from state
  always_comb begin
    cmd        = '0;
    in_ready   = (state_r == S_IDLE);
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.scan   = (state_r == S_SCAN);
    cmd.rd     = (state_r == S_READ) || (state_r == S_REREAD);
    cmd.rotate = (state_r == S_ROTATE);
    cmd.emit   = (state_r == S_EMIT) && !status.out_busy;
  end

  // Advance through one tick
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SCAN;
      S_SCAN:   if (status.scan_last) state_nxt = S_READ;
      S_READ:   state_nxt = S_ROTATE;
      S_ROTATE: state_nxt = S_REREAD;
      S_REREAD: state_nxt = S_EMIT;
      S_EMIT:   if (!status.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/round_robin_scheduler.sv
// Round-robin time-slice scheduler, one tick word in, one result word out.
// After input accept the arrival scan checks one process index per cycle, then
// head read, rotation, head re-read and emit follow; emit waits while the output
// word is held. A new tick word is taken only after the last one is emitted.
// Reset (rst_n low, synchronous): queue empty, no process queued, quantum
// and slice 4, no result pending. Queue memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_scheduler (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  rrs_pkg::in_word_t       in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output rrs_pkg::out_word_t      out_data,
  input  wire                     cfg_we,
  input  wire [rrs_pkg::TQ_W-1:0] cfg_data
);
  import rrs_pkg::*;

  rrs_cmd_t    cmd;
  rrs_status_t status;

  rrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rrs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // Every queued flag matches exactly one queue entry
  a_flags_match_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(status.queued) == int'(status.fill))
    else $error("queued flags disagree with queue fill");

  // Queue never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.fill <= FILL_W'(FIFO_DEPTH))
    else $error("queue fill beyond depth");

  // One word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a tick is in progress");

  // A result is emitted only when the output slot can take it
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result emitted over a pending word");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for round_robin_scheduler: tick words in, run words out.
// Keeps its own copy of the ready queue and slice counter to predict each run word.
// Depends on rrs_pkg and round_robin_scheduler.
`timescale 1ns / 1ps

module tb_top;
  import rrs_pkg::*;

  localparam int CYC_LIMIT = 600000;
  localparam int SLOT_CNT  = 4096;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_data;
  logic              cfg_we = 1'b0;
  logic [TQ_W-1:0]   cfg_data = '0;

  // Tick words waiting to be sent and run words waiting to arrive,
  // kept in flat buffers with write and read counts
  in_word_t  tick_buf[SLOT_CNT];
  int        tick_wr = 0;
  int        tick_rd = 0;
  out_word_t run_expect_buf[SLOT_CNT];
  int        exp_wr = 0;
  int        exp_rd = 0;

  int err_cnt = 0;
  int cyc = 0;
  int send_odds = 0;
  int stall_odds = 0;

  // Scheduler state as predicted by the testbench
  logic [RUN_IDX_W-1:0] q_slot[FIFO_DEPTH];
  logic [ADDR_W-1:0]    q_head = '0;
  logic [FILL_W-1:0]    q_fill = '0;
  logic [PROC_CNT-1:0]  q_member = '0;
  logic [TQ_W-1:0]      slice_cnt = TQ_RESET;
  logic [TQ_W-1:0]      quantum = TQ_RESET;

  round_robin_scheduler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Append a process to the predicted ready queue; drop it when full
  function automatic void queue_append(input logic [RUN_IDX_W-1:0] proc);
    if (q_fill < FIFO_DEPTH) begin
      q_slot[ADDR_W'(q_head + q_fill)] = proc;
      q_fill++;
    end
  endfunction

  // Advance the predicted scheduler by one tick and return the run word
  function automatic out_word_t sched_tick(input in_word_t w);
    out_word_t            r;
    logic [RUN_IDX_W-1:0] hd;
    logic                 hd_done;
    for (int i = 0; i < PROC_CNT; i++) begin
      if (w.arrived_mask[i] && !w.done_mask[i] && !q_member[i]) begin
        queue_append(RUN_IDX_W'(i));
        q_member[i] = 1'b1;
      end
    end
    // Rotate or retire the head on slice expiry or completion
    if (q_fill > 0) begin
      hd      = q_slot[q_head];
      hd_done = w.done_mask[hd];
      if (slice_cnt == 0 || hd_done) begin
        q_head++;
        q_fill--;
        if (hd_done)
          q_member[hd] = 1'b0;
        else
          queue_append(hd);
        slice_cnt = quantum;
      end
    end
    if (q_fill > 0) begin
      r.run_valid = 1'b1;
      r.run_index = q_slot[q_head];
      if (slice_cnt > 0)
        slice_cnt--;
    end else begin
      r = '0;
      slice_cnt = '0;
    end
    return r;
  endfunction

  // Drive tick words; predict each one as it is accepted
  always @(posedge clk) begin : drive_p
    logic     nxt_valid;
    in_word_t nxt_data;
    int       gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && in_ready) begin
        run_expect_buf[exp_wr] = sched_tick(in_data);
        exp_wr++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_rd < tick_wr) begin
          if (send_odds != 0 && $urandom_range(0, send_odds - 1) == 0) begin
            gap_left = $urandom_range(1, 18) - 1;
          end else begin
            nxt_valid = 1'b1;
            nxt_data  = tick_buf[tick_rd];
            tick_rd++;
          end
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // Take run words and check them against the oldest prediction
  always @(posedge clk) begin : recv_p
    out_word_t exp_w;
    logic      nxt_ready;
    int        got_cnt;
    int        stall_left;
    int        hold_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      got_cnt    = 0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_rd >= exp_wr) begin
          $error("unexpected run word: run_valid %0d run_index %0d",
                 out_data.run_valid, out_data.run_index);
          err_cnt++;
        end else begin
          exp_w = run_expect_buf[exp_rd];
          exp_rd++;
          if (out_data.run_valid !== exp_w.run_valid) begin
            $error("run_valid: expected %0d, got %0d", exp_w.run_valid, out_data.run_valid);
            err_cnt++;
          end
          if (out_data.run_index !== exp_w.run_index) begin
            $error("run_index: expected %0d, got %0d", exp_w.run_index, out_data.run_index);
            err_cnt++;
          end
        end
        got_cnt++;
        // Hold off once for a long stretch so the block backs up
        if (got_cnt == 150)
          hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        nxt_ready  = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_tick(input logic [MASK_W-1:0] arr, input logic [MASK_W-1:0] dn);
    if (tick_wr < SLOT_CNT) begin
      tick_buf[tick_wr] = in_word_t'{arrived_mask: arr, done_mask: dn};
      tick_wr++;
    end
  endtask

  // Fill the queue with job sets: processes arrive, run, then finish;
  // mix in stray words and the odd flipped bit
  task automatic add_workload(input int budget);
    int          made;
    int          span;
    int          last;
    int          arr_at[PROC_CNT];
    int          fin_at[PROC_CNT];
    logic [15:0] pset;
    logic [15:0] a_m;
    logic [15:0] d_m;
    made = 0;
    while (made < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        push_tick(16'($urandom), 16'($urandom));
        made++;
      end else begin
        span = $urandom_range(2, 40);
        pset = 16'($urandom);
        if ($urandom_range(0, 1) == 0)
          pset = pset & 16'($urandom);
        last = 0;
        for (int i = 0; i < PROC_CNT; i++) begin
          arr_at[i] = $urandom_range(0, span);
          fin_at[i] = arr_at[i] + $urandom_range(1, 2 * span);
          if (pset[i] && fin_at[i] > last)
            last = fin_at[i];
        end
        for (int t = 0; t <= last + 1 && made < budget; t++) begin
          for (int i = 0; i < PROC_CNT; i++) begin
            a_m[i] = pset[i] && t >= arr_at[i];
            d_m[i] = pset[i] && t >= fin_at[i];
          end
          if ($urandom_range(0, 19) == 0)
            a_m[$urandom_range(0, 15)] ^= 1'b1;
          if ($urandom_range(0, 19) == 0)
            d_m[$urandom_range(0, 15)] ^= 1'b1;
          push_tick(a_m, d_m);
          made++;
        end
      end
    end
  endtask

  // Hold until every queued word is sent and every run word is back
  task automatic wait_drained();
    while (tick_rd < tick_wr || in_valid || exp_rd < exp_wr)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [TQ_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    quantum = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [TQ_W-1:0] tq, input int n, input int odds);
    write_quantum(tq);
    send_odds  = odds;
    stall_odds = odds;
    add_workload(n);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_odds  = 3;
    stall_odds = 3;

    // Directed: empty queue, full queue, rotation at the reset quantum
    push_tick(16'h0000, 16'h0000);
    push_tick(16'hFFFF, 16'h0000);
    repeat (4) push_tick(16'hFFFF, 16'h0000);
    // Done while queued behind the head, then done at the head
    push_tick(16'hFFFF, 16'h0002);
    // Everyone done: one head retired per tick until the queue drains
    repeat (17) push_tick(16'hFFFF, 16'hFFFF);
    // Arrived and done together never enters the queue
    push_tick(16'h00F0, 16'h00F0);
    wait_drained();

    // Random: sweep the quantum across its range, some phases without idling
    run_phase(8'd1, 300, 3);
    run_phase(8'd255, 250, 4);
    run_phase(8'd0, 250, 0);
    run_phase(8'd2, 300, 3);
    run_phase(8'($urandom_range(3, 20)), 300, 2);
    run_phase(8'($urandom_range(1, 255)), 250, 5);
    run_phase(8'd3, 250, 0);

    if (err_cnt == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: round_robin_scheduler.f
src/rrs_pkg.sv
src/rrs_dp.sv
src/rrs_ctrl.sv
src/round_robin_scheduler.sv
tb/tb_top.sv
